// ===== rtl/core/c2p_pkg.sv =====
// c2p_pkg: widths, constants, types and the arctangent table for the
// cartesian_to_polar CORDIC pipeline. No dependencies.
package c2p_pkg;

   // Field widths and pipeline shape
   localparam int COORD_WIDTH = 24;
   localparam int ITERATIONS  = 20;
   localparam int ANGLE_WIDTH = 25;

   // Guard bits on the vector, vector width keeps headroom for CORDIC gain
   localparam int GUARD_BITS = 54 - COORD_WIDTH;
   localparam int VEC_W      = COORD_WIDTH + GUARD_BITS + 2;
   // Angle accumulator, degrees with 24 fractional bits
   localparam int ANG_ACC_W  = 33;
   // First-quadrant angle, degrees with 16 fractional bits, at most 90
   localparam int ANG_Q1_W   = 23;
   localparam int SHIFT_W    = $clog2(ITERATIONS);
   // Prep stage, one stage per iteration, gain multiply, output stage
   localparam int NUM_STAGES = ITERATIONS + 3;

   // Gain correction datapath
   localparam int Q_W   = COORD_WIDTH + 9;
   localparam int HI_W  = Q_W - 16;
   localparam int INV_W = 32;
   localparam int PHI_W = HI_W + INV_W;
   localparam int PLO_W = 16 + INV_W;
   localparam int R_W   = PHI_W + 1;
   localparam int M_W   = R_W - 24;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;

   localparam logic [INV_W-1:0]           INV_GAIN_Q32 = 32'h9B74EDA8;
   localparam longint unsigned            RAD2DEG_Q24  = 64'd961263669;
   localparam logic signed [ANG_ACC_W-1:0] DEG90_Q24   = ANG_ACC_W'(64'd90 << 24);
   localparam logic [ANG_Q1_W-1:0]        DEG90_Q16    = ANG_Q1_W'(64'd90 << 16);
   localparam logic signed [ANGLE_WIDTH-1:0] DEG180_Q16 = ANGLE_WIDTH'(64'd180 << 16);
   localparam logic [COORD_WIDTH-1:0]     MAG_MAX      = {COORD_WIDTH{1'b1}};

   // Classification of a point, decided at the input
   typedef enum logic [1:0] {
      PT_GENERAL,
      PT_ORIGIN,
      PT_X_AXIS,
      PT_Y_AXIS
   } point_kind_type;

   // Side information that rides along with the vector
   typedef struct packed {
      logic                   x_neg;
      logic                   y_neg;
      point_kind_type         kind;
      logic [COORD_WIDTH-1:0] axis_mag;
   } side_type;

   // CORDIC vector and angle accumulator
   typedef struct packed {
      logic signed [VEC_W-1:0]     x;
      logic signed [VEC_W-1:0]     y;
      logic signed [ANG_ACC_W-1:0] z;
   } vec_type;

   // atan(2^-i) in degrees, Q24; beyond the table it is (180/pi) >> i, rounded
   function automatic logic signed [ANG_ACC_W-1:0] atan_entry(input int unsigned idx);
      longint unsigned v;
      case (idx)
         0:  v = 64'd754974720;
         1:  v = 64'd445687602;
         2:  v = 64'd235489088;
         3:  v = 64'd119537938;
         4:  v = 64'd60000934;
         5:  v = 64'd30029717;
         6:  v = 64'd15018523;
         7:  v = 64'd7509720;
         8:  v = 64'd3754917;
         9:  v = 64'd1877466;
         10: v = 64'd938734;
         11: v = 64'd469367;
         12: v = 64'd234684;
         13: v = 64'd117342;
         14: v = 64'd58671;
         15: v = 64'd29335;
         default: v = (RAD2DEG_Q24 + (64'd1 << (idx - 1))) >> idx;
      endcase
      return ANG_ACC_W'(v);
   endfunction

endpackage

// ===== rtl/core/c2p_prep.sv =====
// c2p_prep: input stage; folds the point into the first quadrant, classifies
// it and loads the scaled CORDIC vector. Depends on c2p_pkg.
module c2p_prep (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               valid_in,
   input  logic [c2p_pkg::COORD_WIDTH-1:0]    x_coord,
   input  logic [c2p_pkg::COORD_WIDTH-1:0]    y_coord,
   output logic                               valid_ff,
   output c2p_pkg::vec_type                   vec_ff,
   output c2p_pkg::side_type                  side_ff
);

   logic [c2p_pkg::COORD_WIDTH-1:0] ax;
   logic [c2p_pkg::COORD_WIDTH-1:0] ay;
   c2p_pkg::vec_type                vec_in;
   c2p_pkg::side_type               side_in;

   // Absolute values; the most negative code maps to its unsigned magnitude
   assign ax = x_coord[c2p_pkg::COORD_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;
   assign ay = y_coord[c2p_pkg::COORD_WIDTH-1] ? (~y_coord + 1'b1) : y_coord;

   // Classify and scale up by the guard bits
   always_comb begin
      side_in.x_neg = x_coord[c2p_pkg::COORD_WIDTH-1];
      side_in.y_neg = y_coord[c2p_pkg::COORD_WIDTH-1];
      if (ax == '0 && ay == '0) begin
         side_in.kind = c2p_pkg::PT_ORIGIN;
      end else if (ay == '0) begin
         side_in.kind = c2p_pkg::PT_X_AXIS;
      end else if (ax == '0) begin
         side_in.kind = c2p_pkg::PT_Y_AXIS;
      end else begin
         side_in.kind = c2p_pkg::PT_GENERAL;
      end
      side_in.axis_mag = (side_in.kind == c2p_pkg::PT_Y_AXIS) ? ay : ax;
      vec_in.x = signed'(c2p_pkg::VEC_W'(ax) << c2p_pkg::GUARD_BITS);
      vec_in.y = signed'(c2p_pkg::VEC_W'(ay) << c2p_pkg::GUARD_BITS);
      vec_in.z = '0;
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_in;
         side_ff <= side_in;
      end
   end

endmodule

// ===== rtl/core/c2p_cordic_stage.sv =====
// c2p_cordic_stage: one vectoring-mode CORDIC micro-rotation and its stage
// register. Depends on c2p_pkg.
module c2p_cordic_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic [c2p_pkg::SHIFT_W-1:0]          shift,
   input  logic signed [c2p_pkg::ANG_ACC_W-1:0] atan_step,
   input  logic                                 valid_in,
   input  c2p_pkg::vec_type                     vec_in,
   input  c2p_pkg::side_type                    side_in,
   output logic                                 valid_ff,
   output c2p_pkg::vec_type                     vec_ff,
   output c2p_pkg::side_type                    side_ff
);

   logic signed [c2p_pkg::VEC_W-1:0] dx;
   logic signed [c2p_pkg::VEC_W-1:0] dy;
   c2p_pkg::vec_type                 vec_in_next;

   // Arithmetic shifts round toward minus infinity
   assign dx = vec_in.x >>> shift;
   assign dy = vec_in.y >>> shift;

   // Rotate toward the x axis by the sign of y
   always_comb begin
      if (!vec_in.y[c2p_pkg::VEC_W-1]) begin
         vec_in_next.x = vec_in.x + dy;
         vec_in_next.y = vec_in.y - dx;
         vec_in_next.z = vec_in.z + atan_step;
      end else begin
         vec_in_next.x = vec_in.x - dy;
         vec_in_next.y = vec_in.y + dx;
         vec_in_next.z = vec_in.z - atan_step;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_in_next;
         side_ff <= side_in;
      end
   end

endmodule

// ===== rtl/core/c2p_post.sv =====
// c2p_post: gain removal, rounding, saturation and quadrant restore over two
// register stages; the second is the output register. Depends on c2p_pkg.
module c2p_post (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en_a,
   input  logic                                   en_b,
   input  logic                                   valid_in,
   input  c2p_pkg::vec_type                       vec_in,
   input  c2p_pkg::side_type                      side_in,
   output logic                                   valid_a_ff,
   output logic                                   valid_b_ff,
   output logic [c2p_pkg::COORD_WIDTH-1:0]        mag_ff,
   output logic signed [c2p_pkg::ANGLE_WIDTH-1:0] ang_ff
);

   // Stage A signals
   logic [c2p_pkg::Q_W-1:0]                q;
   logic [c2p_pkg::PHI_W-1:0]              prod_hi_in;
   logic [c2p_pkg::PLO_W-1:0]              prod_lo;
   logic [c2p_pkg::INV_W-1:0]              lo_sh_in;
   logic signed [c2p_pkg::ANG_ACC_W-1:0]   zc;
   logic [c2p_pkg::ANG_ACC_W-1:0]          zr;
   logic [c2p_pkg::ANG_Q1_W-1:0]           a_in;
   logic [c2p_pkg::PHI_W-1:0]              prod_hi_ff;
   logic [c2p_pkg::INV_W-1:0]              lo_sh_ff;
   logic [c2p_pkg::ANG_Q1_W-1:0]           a_ff;
   c2p_pkg::side_type                      side_a_ff;

   // Stage B signals
   logic [c2p_pkg::R_W-1:0]                r;
   logic [c2p_pkg::R_W-1:0]                rr;
   logic [c2p_pkg::M_W-1:0]                m;
   logic [c2p_pkg::COORD_WIDTH-1:0]        mag_sat;
   logic [c2p_pkg::COORD_WIDTH-1:0]        mag_in;
   logic signed [c2p_pkg::ANGLE_WIDTH-1:0] a_s;
   logic signed [c2p_pkg::ANGLE_WIDTH-1:0] ang_in;

   // Gain multiply: split the scaled x into high and low halves
   assign q          = vec_in.x[c2p_pkg::GUARD_BITS-8 +: c2p_pkg::Q_W];
   assign prod_hi_in = c2p_pkg::PHI_W'(q[c2p_pkg::Q_W-1:16])
                       * c2p_pkg::PHI_W'(c2p_pkg::INV_GAIN_Q32);
   assign prod_lo    = c2p_pkg::PLO_W'(q[15:0]) * c2p_pkg::PLO_W'(c2p_pkg::INV_GAIN_Q32);
   assign lo_sh_in   = prod_lo[c2p_pkg::PLO_W-1:16];

   // First-quadrant angle: clamp to [0, 90] and round to Q16
   always_comb begin
      if (vec_in.z < 0) begin
         zc = '0;
      end else if (vec_in.z > c2p_pkg::DEG90_Q24) begin
         zc = c2p_pkg::DEG90_Q24;
      end else begin
         zc = vec_in.z;
      end
      zr = unsigned'(zc) + c2p_pkg::ANG_ACC_W'(128);
      case (side_in.kind)
         c2p_pkg::PT_GENERAL: a_in = zr[8 +: c2p_pkg::ANG_Q1_W];
         c2p_pkg::PT_Y_AXIS:  a_in = c2p_pkg::DEG90_Q16;
         default:             a_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en_a) begin
         valid_a_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         prod_hi_ff <= prod_hi_in;
         lo_sh_ff   <= lo_sh_in;
         a_ff       <= a_in;
         side_a_ff  <= side_in;
      end
   end

   // Magnitude: sum partial products, round half up, saturate
   assign r  = c2p_pkg::R_W'(prod_hi_ff) + c2p_pkg::R_W'(lo_sh_ff);
   assign rr = r + c2p_pkg::R_W'(64'd1 << 23);
   assign m  = rr[c2p_pkg::R_W-1:24];
   assign mag_sat = (m > c2p_pkg::M_W'(c2p_pkg::MAG_MAX)) ? c2p_pkg::MAG_MAX
                                                         : m[c2p_pkg::COORD_WIDTH-1:0];

   always_comb begin
      case (side_a_ff.kind)
         c2p_pkg::PT_GENERAL: mag_in = mag_sat;
         c2p_pkg::PT_ORIGIN:  mag_in = '0;
         default:             mag_in = side_a_ff.axis_mag;
      endcase
   end

   // Restore the quadrant from the input signs
   assign a_s = signed'(c2p_pkg::ANGLE_WIDTH'(a_ff));

   always_comb begin
      if (!side_a_ff.x_neg) begin
         ang_in = side_a_ff.y_neg ? -a_s : a_s;
      end else if (!side_a_ff.y_neg) begin
         ang_in = c2p_pkg::DEG180_Q16 - a_s;
      end else if (a_s == '0) begin
         // would land on -180: keep the open end of the range
         ang_in = -c2p_pkg::DEG180_Q16 + c2p_pkg::ANGLE_WIDTH'(1);
      end else begin
         ang_in = a_s - c2p_pkg::DEG180_Q16;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en_b) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         mag_ff <= mag_in;
         ang_ff <= ang_in;
      end
   end

endmodule

// ===== rtl/core/cartesian_to_polar.sv =====
// cartesian_to_polar: top level of the fully unrolled CORDIC vectoring pipeline.
// Depends on c2p_pkg, c2p_prep, c2p_cordic_stage and c2p_post.
//
// Usage:
//   req channel carries one point per transfer: x_coord and y_coord, signed.
//   rsp channel returns one result per point, in order: the rounded magnitude
//   at the input scale and atan2(y, x) in degrees, Q16, within (-180, 180].
//   The point passes 23 register stages: one input stage, one stage per
//   CORDIC iteration (20), the gain multiply stage and the output register.
//   rsp_tvalid rises once the point reaches the output register. Throughput
//   is one point per cycle while the receiver keeps rsp_tready high.
//   Every stage holds a valid bit; a stage loads when it is empty or when the
//   stage after it moves, so bubbles close up while the receiver stalls and
//   req_tready only drops once every stage holds a point.
//   A stall holds the output register; nothing is lost or repeated.
//   Synchronous reset empties the pipeline; there is no other state.
module cartesian_to_polar (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [23:0] x_coord, [47:24] y_coord
   input  logic [c2p_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [23:0] magnitude, [48:24] angle_deg, upper bits zero
   output logic [c2p_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int LAST = c2p_pkg::NUM_STAGES - 1;

   logic                                   stage_valid [c2p_pkg::NUM_STAGES];
   logic                                   stage_en    [c2p_pkg::NUM_STAGES];
   c2p_pkg::vec_type                       cordic_vec  [c2p_pkg::ITERATIONS+1];
   c2p_pkg::side_type                      cordic_side [c2p_pkg::ITERATIONS+1];
   logic [c2p_pkg::COORD_WIDTH-1:0]        mag;
   logic signed [c2p_pkg::ANGLE_WIDTH-1:0] ang;

   // Stage enables: load when empty or when the next stage moves
   assign stage_en[LAST] = !stage_valid[LAST] || rsp_tready;
   for (genvar k = 0; k < LAST; k++) begin : g_en
      assign stage_en[k] = !stage_valid[k] || stage_en[k+1];
   end

   assign req_tready = stage_en[0];

   // Input stage
   c2p_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (stage_en[0]),
      .valid_in (req_tvalid),
      .x_coord  (req_tdata[0 +: c2p_pkg::COORD_WIDTH]),
      .y_coord  (req_tdata[c2p_pkg::COORD_WIDTH +: c2p_pkg::COORD_WIDTH]),
      .valid_ff (stage_valid[0]),
      .vec_ff   (cordic_vec[0]),
      .side_ff  (cordic_side[0])
   );

   // CORDIC iterations, one per stage
   for (genvar g = 0; g < c2p_pkg::ITERATIONS; g++) begin : g_iter
      c2p_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (stage_en[g+1]),
         .shift     (c2p_pkg::SHIFT_W'(g)),
         .atan_step (c2p_pkg::atan_entry(g)),
         .valid_in  (stage_valid[g]),
         .vec_in    (cordic_vec[g]),
         .side_in   (cordic_side[g]),
         .valid_ff  (stage_valid[g+1]),
         .vec_ff    (cordic_vec[g+1]),
         .side_ff   (cordic_side[g+1])
      );
   end

   // Gain removal, rounding and output register
   c2p_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en_a       (stage_en[c2p_pkg::ITERATIONS+1]),
      .en_b       (stage_en[LAST]),
      .valid_in   (stage_valid[c2p_pkg::ITERATIONS]),
      .vec_in     (cordic_vec[c2p_pkg::ITERATIONS]),
      .side_in    (cordic_side[c2p_pkg::ITERATIONS]),
      .valid_a_ff (stage_valid[c2p_pkg::ITERATIONS+1]),
      .valid_b_ff (stage_valid[LAST]),
      .mag_ff     (mag),
      .ang_ff     (ang)
   );

   assign rsp_tvalid = stage_valid[LAST];
   assign rsp_tdata  = c2p_pkg::RSP_DATA_W'({ang, mag});

endmodule

// ===== rtl/core/c2p_checker.sv =====
// c2p_checker: port-level assertions for cartesian_to_polar, bound to the top.
// Depends on c2p_pkg.
module c2p_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [c2p_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [c2p_pkg::COORD_WIDTH-1:0]        rsp_mag;
   logic signed [c2p_pkg::ANGLE_WIDTH-1:0] rsp_ang;

   assign rsp_mag  = rsp_tdata[0 +: c2p_pkg::COORD_WIDTH];
   assign rsp_ang  = signed'(rsp_tdata[c2p_pkg::COORD_WIDTH +: c2p_pkg::ANGLE_WIDTH]);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its data
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // Angle stays in the half-open range (-180, 180]
   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ang > -c2p_pkg::DEG180_Q16) && (rsp_ang <= c2p_pkg::DEG180_Q16))
      else $error("angle out of range");

   // Only the origin gives zero magnitude, and its angle is zero
   a_origin_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_mag == '0 |-> rsp_ang == '0)
      else $error("zero magnitude with nonzero angle");

endmodule

bind cartesian_to_polar c2p_checker u_checker (.*);
